// ===== hdl/bsw_pkg.sv =====
// Package for the BCD stopwatch with lap capture: field widths, register
// indexes, button codes, LED patterns and the shared structure types.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package bsw_pkg;

   // Field widths.
   localparam int DIGITS_W  = 20;
   localparam int SAMPLE_W  = 10;
   localparam int LEVEL_W   = 10;
   localparam int STEP_W    = 8;
   localparam int ACCUM_W   = 9;
   localparam int CODE_W    = 3;
   localparam int LED_W     = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 10;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_TICK_STEP     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TICK_LIMIT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_LEVEL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_LEVEL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UP_LEVEL      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DOWN_LEVEL    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_LEVEL    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SELECT_LEVEL  = 3'd7;

   // Register reset values.
   localparam logic [STEP_W-1:0]  RST_TICK_STEP     = 8'd10;
   localparam logic [STEP_W-1:0]  RST_TICK_LIMIT    = 8'd61;
   localparam logic [LEVEL_W-1:0] RST_RELEASE_LEVEL = 10'h317;
   localparam logic [LEVEL_W-1:0] RST_RIGHT_LEVEL   = 10'h032;
   localparam logic [LEVEL_W-1:0] RST_UP_LEVEL      = 10'h0C3;
   localparam logic [LEVEL_W-1:0] RST_DOWN_LEVEL    = 10'h17C;
   localparam logic [LEVEL_W-1:0] RST_LEFT_LEVEL    = 10'h22B;
   localparam logic [LEVEL_W-1:0] RST_SELECT_LEVEL  = 10'h316;

   // Button codes.
   localparam logic [CODE_W-1:0] BTN_NONE   = 3'd0;
   localparam logic [CODE_W-1:0] BTN_RIGHT  = 3'd1;
   localparam logic [CODE_W-1:0] BTN_UP     = 3'd2;
   localparam logic [CODE_W-1:0] BTN_DOWN   = 3'd3;
   localparam logic [CODE_W-1:0] BTN_LEFT   = 3'd4;
   localparam logic [CODE_W-1:0] BTN_SELECT = 3'd5;

   // LED patterns.
   localparam logic [LED_W-1:0] LED_B_RELEASE = 8'h02;
   localparam logic [LED_W-1:0] LED_B_HELD    = 8'h08;
   localparam logic [LED_W-1:0] LED_L_OFF     = 8'h00;
   localparam logic [LED_W-1:0] LED_L_UP      = 8'h08;
   localparam logic [LED_W-1:0] LED_L_DOWN    = 8'h02;
   localparam logic [LED_W-1:0] LED_L_LEFT    = 8'h20;
   localparam logic [LED_W-1:0] LED_L_SELECT  = 8'h80;

   // Largest value of each BCD digit, tenths first.
   localparam int NUM_DIGITS = 5;
   localparam logic [3:0] DIGIT_MAX [NUM_DIGITS] = '{4'd9, 4'd9, 4'd5, 4'd9, 4'd9};

   // Ladder thresholds handed to the button decoder.
   typedef struct packed {
      logic [LEVEL_W-1:0] release_level;
      logic [LEVEL_W-1:0] right_level;
      logic [LEVEL_W-1:0] up_level;
      logic [LEVEL_W-1:0] down_level;
      logic [LEVEL_W-1:0] left_level;
      logic [LEVEL_W-1:0] select_level;
   } bsw_levels_type;

   // Press latch and LED state going in and out of the decoder.
   typedef struct packed {
      logic             latch;
      logic [LED_W-1:0] led_b;
      logic [LED_W-1:0] led_l;
   } bsw_btn_state_type;

   // One result beat.
   typedef struct packed {
      logic [DIGITS_W-1:0] time_digits;
      logic [DIGITS_W-1:0] shown_lap_start;
      logic [DIGITS_W-1:0] shown_lap_end;
      logic                lap_visible;
      logic                running;
      logic [CODE_W-1:0]   button_code;
      logic [LED_W-1:0]    led_bank_b;
      logic [LED_W-1:0]    led_bank_l;
   } bsw_rsp_type;

endpackage

`default_nettype wire

// ===== hdl/bsw_if.sv =====
// Valid/ready channel interfaces for the stopwatch input and result beats.
// Depends on bsw_pkg for the field widths.
`default_nettype none

interface bsw_req_if;
   logic                           valid;
   logic                           ready;
   logic                           tick;
   logic                           sample_valid;
   logic [bsw_pkg::SAMPLE_W-1:0]   adc_sample;

   modport source (output valid, tick, sample_valid, adc_sample, input ready);
   modport sink   (input valid, tick, sample_valid, adc_sample, output ready);
endinterface

interface bsw_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bsw_pkg::DIGITS_W-1:0]   time_digits;
   logic [bsw_pkg::DIGITS_W-1:0]   shown_lap_start;
   logic [bsw_pkg::DIGITS_W-1:0]   shown_lap_end;
   logic                           lap_visible;
   logic                           running;
   logic [bsw_pkg::CODE_W-1:0]     button_code;
   logic [bsw_pkg::LED_W-1:0]      led_bank_b;
   logic [bsw_pkg::LED_W-1:0]      led_bank_l;

   modport source (output valid, time_digits, shown_lap_start, shown_lap_end, lap_visible,
                   running, button_code, led_bank_b, led_bank_l, input ready);
   modport sink   (input valid, time_digits, shown_lap_start, shown_lap_end, lap_visible,
                   running, button_code, led_bank_b, led_bank_l, output ready);
endinterface

`default_nettype wire

// ===== hdl/bcd_stopwatch_with_lap.sv =====
// Top level of the BCD stopwatch with lap capture: configuration registers,
// stopwatch state and the registered result stage.
// Depends on bsw_pkg, bsw_if, bsw_btn_dec and bsw_tenth_adv.
//
//   channel  | direction | handshake         | contents
//   ---------+-----------+-------------------+----------------------------------
//   req_chan | in        | valid/ready       | tick, sample_valid, adc_sample
//   rsp_chan | out       | valid/ready       | time, lap row, run, code, LEDs
//   csr_*    | in        | write enable only | register index and write data
//
// Each input beat gives one result beat in the cycle after acceptance; the
// state update is a single pass through the decoder, the tick accumulator
// and the five-digit carry chain, so one beat can be accepted every cycle.
// req_chan.ready is low only while a result waits and rsp_chan.ready is low.
// Synchronous reset loads register reset values and clears all state but rsp_ff.
`default_nettype none

module bcd_stopwatch_with_lap (
   input  wire logic                          clock,
   input  wire logic                          reset,
   bsw_req_if.sink                            req_chan,
   bsw_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_we,
   input  wire logic [bsw_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bsw_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import bsw_pkg::*;

   // Configuration registers.
   logic [STEP_W-1:0] tick_step_ff, tick_limit_ff;
   bsw_levels_type    levels_ff;

   // Stopwatch state.
   logic [DIGITS_W-1:0] clock_digits_ff, clock_digits_in;
   logic [DIGITS_W-1:0] lap_origin_ff, lap_origin_in;
   logic [DIGITS_W-1:0] lap_start_ff, lap_start_in;
   logic [DIGITS_W-1:0] lap_end_ff, lap_end_in;
   logic                lap_row_ff, lap_row_in;
   logic                run_ff, run_in;
   logic [ACCUM_W-1:0]  accum_ff, accum_in;
   bsw_btn_state_type   btn_ff, btn_in, btn_dec;

   // Result stage.
   logic        rsp_valid_ff, rsp_valid_in;
   bsw_rsp_type rsp_ff, rsp_in;

   logic                accept;
   logic [CODE_W-1:0]   dec_code, code;
   logic [DIGITS_W-1:0] btn_digits, adv_digits;
   logic [STEP_W-1:0]   step;
   logic [ACCUM_W:0]    accum_sum;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_step_ff            <= RST_TICK_STEP;
         tick_limit_ff           <= RST_TICK_LIMIT;
         levels_ff.release_level <= RST_RELEASE_LEVEL;
         levels_ff.right_level   <= RST_RIGHT_LEVEL;
         levels_ff.up_level      <= RST_UP_LEVEL;
         levels_ff.down_level    <= RST_DOWN_LEVEL;
         levels_ff.left_level    <= RST_LEFT_LEVEL;
         levels_ff.select_level  <= RST_SELECT_LEVEL;
      end else if (csr_we) begin
         case (csr_index)
            REG_TICK_STEP:     tick_step_ff            <= csr_wdata[STEP_W-1:0];
            REG_TICK_LIMIT:    tick_limit_ff           <= csr_wdata[STEP_W-1:0];
            REG_RELEASE_LEVEL: levels_ff.release_level <= csr_wdata;
            REG_RIGHT_LEVEL:   levels_ff.right_level   <= csr_wdata;
            REG_UP_LEVEL:      levels_ff.up_level      <= csr_wdata;
            REG_DOWN_LEVEL:    levels_ff.down_level    <= csr_wdata;
            REG_LEFT_LEVEL:    levels_ff.left_level    <= csr_wdata;
            REG_SELECT_LEVEL:  levels_ff.select_level  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   bsw_btn_dec u_btn_dec (
      .sample (req_chan.adc_sample),
      .levels (levels_ff),
      .cur    (btn_ff),
      .nxt    (btn_dec),
      .code   (dec_code)
   );

   bsw_tenth_adv u_tenth_adv (
      .cur_time (btn_digits),
      .nxt_time (adv_digits)
   );

   // Button actions come first; the tick works on what they leave.
   always_comb begin
      code         = BTN_NONE;
      btn_in       = btn_ff;
      btn_digits   = clock_digits_ff;
      lap_origin_in = lap_origin_ff;
      lap_start_in = lap_start_ff;
      lap_end_in   = lap_end_ff;
      lap_row_in   = lap_row_ff;
      run_in       = run_ff;
      if (req_chan.sample_valid) begin
         code   = dec_code;
         btn_in = btn_dec;
         case (dec_code)
            BTN_UP: begin
               lap_start_in  = lap_origin_ff;
               lap_end_in    = clock_digits_ff;
               lap_origin_in = clock_digits_ff;
               lap_row_in    = 1'b1;
            end
            BTN_DOWN: begin
               lap_origin_in = '0;
               lap_row_in    = 1'b0;
            end
            BTN_LEFT: begin
               btn_digits    = '0;
               lap_origin_in = '0;
               run_in        = 1'b0;
            end
            BTN_SELECT: run_in = !run_ff;
            default: begin
            end
         endcase
      end
   end

   // Tick accumulator: the step is clamped to the limit, and one tenth
   // elapses (the digits advance only while running) when the sum reaches the limit.
   always_comb begin
      step            = (tick_step_ff > tick_limit_ff) ? tick_limit_ff : tick_step_ff;
      accum_sum       = {1'b0, accum_ff} + {{(ACCUM_W+1-STEP_W){1'b0}}, step};
      accum_in        = accum_ff;
      clock_digits_in = btn_digits;
      if (req_chan.tick) begin
         if (accum_sum >= {{(ACCUM_W+1-STEP_W){1'b0}}, tick_limit_ff}) begin
            if (run_in) begin
               clock_digits_in = adv_digits;
            end
            accum_sum = accum_sum - {{(ACCUM_W+1-STEP_W){1'b0}}, tick_limit_ff};
         end
         accum_in = accum_sum[ACCUM_W-1:0];
      end
   end

   // Result beat assembled from the next state.
   always_comb begin
      rsp_in.time_digits     = clock_digits_in;
      rsp_in.shown_lap_start = lap_row_in ? lap_start_in : '0;
      rsp_in.shown_lap_end   = lap_row_in ? lap_end_in : '0;
      rsp_in.lap_visible     = lap_row_in;
      rsp_in.running         = run_in;
      rsp_in.button_code     = code;
      rsp_in.led_bank_b      = btn_in.led_b;
      rsp_in.led_bank_l      = btn_in.led_l;
      rsp_valid_in           = accept || (rsp_valid_ff && !rsp_chan.ready);
   end

   // State update on each accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_digits_ff <= '0;
         lap_origin_ff   <= '0;
         lap_start_ff    <= '0;
         lap_end_ff      <= '0;
         lap_row_ff      <= 1'b0;
         run_ff          <= 1'b0;
         accum_ff        <= '0;
         btn_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            clock_digits_ff <= clock_digits_in;
            lap_origin_ff   <= lap_origin_in;
            lap_start_ff    <= lap_start_in;
            lap_end_ff      <= lap_end_in;
            lap_row_ff      <= lap_row_in;
            run_ff          <= run_in;
            accum_ff        <= accum_in;
            btn_ff          <= btn_in;
         end
      end
   end

   // Result payload register, loaded on acceptance.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.time_digits     = rsp_ff.time_digits;
   assign rsp_chan.shown_lap_start = rsp_ff.shown_lap_start;
   assign rsp_chan.shown_lap_end   = rsp_ff.shown_lap_end;
   assign rsp_chan.lap_visible     = rsp_ff.lap_visible;
   assign rsp_chan.running         = rsp_ff.running;
   assign rsp_chan.button_code     = rsp_ff.button_code;
   assign rsp_chan.led_bank_b      = rsp_ff.led_bank_b;
   assign rsp_chan.led_bank_l      = rsp_ff.led_bank_l;

endmodule

`default_nettype wire

// ===== hdl/bsw_btn_dec.sv =====
// Button ladder decoder with press latch and LED pattern update.
// Depends on bsw_pkg for the level, state and code definitions.
`default_nettype none

module bsw_btn_dec (
   input  wire logic [bsw_pkg::SAMPLE_W-1:0] sample,
   input  wire bsw_pkg::bsw_levels_type      levels,
   input  wire bsw_pkg::bsw_btn_state_type   cur,
   output bsw_pkg::bsw_btn_state_type        nxt,
   output logic [bsw_pkg::CODE_W-1:0]        code
);
   import bsw_pkg::*;

   // Release clears the latch; a held button repeats as right; a fresh
   // press walks the thresholds from the lowest voltage up.
   always_comb begin
      nxt  = cur;
      code = BTN_NONE;
      if (sample > levels.release_level) begin
         nxt.latch = 1'b0;
         nxt.led_l = LED_L_OFF;
         nxt.led_b = LED_B_RELEASE;
      end else if (cur.latch) begin
         nxt.led_b = LED_B_HELD;
         code      = BTN_RIGHT;
      end else begin
         nxt.latch = 1'b1;
         if (sample < levels.right_level) begin
            nxt.led_b = LED_B_HELD;
            code      = BTN_RIGHT;
         end else if (sample < levels.up_level) begin
            nxt.led_l = LED_L_UP;
            code      = BTN_UP;
         end else if (sample < levels.down_level) begin
            nxt.led_l = LED_L_DOWN;
            code      = BTN_DOWN;
         end else if (sample < levels.left_level) begin
            nxt.led_l = LED_L_LEFT;
            code      = BTN_LEFT;
         end else if (sample <= levels.select_level) begin
            nxt.led_l = LED_L_SELECT;
            code      = BTN_SELECT;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/bsw_tenth_adv.sv =====
// Advances a five-digit BCD mm:ss.t time by one tenth, wrapping at 99:59.9.
// Depends on bsw_pkg for the digit maxima.
`default_nettype none

module bsw_tenth_adv (
   input  wire logic [bsw_pkg::DIGITS_W-1:0] cur_time,
   output logic [bsw_pkg::DIGITS_W-1:0]      nxt_time
);
   import bsw_pkg::*;

   // Ripple a carry from the tenths digit upward; a digit at or above its
   // maximum becomes zero and passes the carry on.
   always_comb begin
      logic       carry;
      logic [3:0] dig;
      carry    = 1'b1;
      nxt_time = cur_time;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         dig = cur_time[i*4 +: 4];
         if (carry) begin
            if (dig >= DIGIT_MAX[i]) begin
               nxt_time[i*4 +: 4] = 4'd0;
            end else begin
               nxt_time[i*4 +: 4] = dig + 4'd1;
               carry              = 1'b0;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/bsw_checker.sv =====
// Port-level checks for the stopwatch top level, attached by bind.
// Depends on bsw_pkg and on the top level's port names.
`default_nettype none

module bsw_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          req_sample_valid,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [bsw_pkg::DIGITS_W-1:0]  rsp_lap_start,
   input wire logic [bsw_pkg::DIGITS_W-1:0]  rsp_lap_end,
   input wire logic                          rsp_lap_visible,
   input wire logic [bsw_pkg::CODE_W-1:0]    rsp_code,
   input wire logic [bsw_pkg::LED_W-1:0]     rsp_led_l
);
   import bsw_pkg::*;

   // A result beat stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // An accepted beat always shows up as a result in the next cycle.
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted beat produced no result");

   // A beat without a sample reports no button.
   a_no_sample_no_code: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_sample_valid |=> rsp_code == BTN_NONE)
      else $error("button code without a sample");

   // A blanked lap row carries zero times.
   a_lap_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_lap_visible |-> rsp_lap_start == '0 && rsp_lap_end == '0)
      else $error("blank lap row shows a time");

   // A lap capture lights the matching LED on port L and shows the lap row.
   a_lap_led: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code == BTN_UP |-> rsp_led_l == LED_L_UP && rsp_lap_visible)
      else $error("lap capture without its LED or lap row");

endmodule

bind bcd_stopwatch_with_lap bsw_checker u_bsw_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_sample_valid (req_chan.sample_valid),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_lap_start    (rsp_chan.shown_lap_start),
   .rsp_lap_end      (rsp_chan.shown_lap_end),
   .rsp_lap_visible  (rsp_chan.lap_visible),
   .rsp_code         (rsp_chan.button_code),
   .rsp_led_l        (rsp_chan.led_bank_l)
);

`default_nettype wire

// ===== verif/bcd_stopwatch_with_lap_tb.sv =====
// Self-checking testbench for the BCD stopwatch with lap capture.
// Drives tick and button ladder beats, predicts each result beat and checks it.
// Depends on bsw_pkg, bsw_if and the bcd_stopwatch_with_lap top level.
`timescale 1ns / 100ps

module bcd_stopwatch_with_lap_tb;
   import bsw_pkg::*;

   localparam int CLK_PERIOD  = 10;
   localparam int RESET_CYCLES = 11;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_BEATS = 185;
   localparam int NUM_PHASES  = 9;
   localparam int HOLD_CYCLES = 200;
   localparam int WRAP_TICKS  = 40;

   // One input beat as queued for the driver.
   typedef struct {
      logic                tick;
      logic                sample_valid;
      logic [SAMPLE_W-1:0] adc_sample;
   } watch_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_TICK_STEP;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   bsw_req_if req_if();
   bsw_rsp_if rsp_if();

   bcd_stopwatch_with_lap i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Beats waiting to be offered and result beats waiting to arrive.
   watch_beat_type pending_beats[$];
   bsw_rsp_type    expected_results[$];

   int pushed_beats   = 0;
   int offered_beats  = 0;
   int accepted_beats = 0;
   int results_seen   = 0;
   int fail_count     = 0;
   int cycle_count    = 0;
   int settings_count = 0;
   int wrap_count     = 0;
   int send_idle_pct  = 23;
   int recv_idle_pct  = 56;

   // Shadow copy of the configuration registers.
   logic [STEP_W-1:0]  cfg_step    = RST_TICK_STEP;
   logic [STEP_W-1:0]  cfg_limit   = RST_TICK_LIMIT;
   logic [LEVEL_W-1:0] cfg_release = RST_RELEASE_LEVEL;
   logic [LEVEL_W-1:0] cfg_right   = RST_RIGHT_LEVEL;
   logic [LEVEL_W-1:0] cfg_up      = RST_UP_LEVEL;
   logic [LEVEL_W-1:0] cfg_down    = RST_DOWN_LEVEL;
   logic [LEVEL_W-1:0] cfg_left    = RST_LEFT_LEVEL;
   logic [LEVEL_W-1:0] cfg_select  = RST_SELECT_LEVEL;

   // Predicted stopwatch state.
   logic [DIGITS_W-1:0] watch_time    = '0;
   logic [DIGITS_W-1:0] lap_base      = '0;
   logic [DIGITS_W-1:0] lap_from      = '0;
   logic [DIGITS_W-1:0] lap_to        = '0;
   logic                lap_shown     = 1'b0;
   logic                watch_running = 1'b0;
   logic                btn_latched   = 1'b0;
   logic [ACCUM_W-1:0]  tick_acc      = '0;
   logic [LED_W-1:0]    leds_b        = '0;
   logic [LED_W-1:0]    leds_l        = '0;

   // Add one tenth to a BCD time, tenths digit first, carrying on each wrap.
   function automatic logic [DIGITS_W-1:0] next_tenth(input logic [DIGITS_W-1:0] t);
      logic [DIGITS_W-1:0] r;
      logic [3:0]          d;
      logic [3:0]          top;
      bit                  done;
      r = t;
      done = 1'b0;
      for (int p = 0; p < NUM_DIGITS; p++) begin
         if (!done) begin
            d = r[p*4 +: 4];
            top = (p == 2) ? 4'd5 : 4'd9;
            if (d >= top) begin
               r[p*4 +: 4] = 4'd0;
            end else begin
               r[p*4 +: 4] = d + 4'd1;
               done = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // Work out the result beat for one accepted input beat and update the state.
   task automatic predict_watch(input logic tick, input logic sample_valid,
                                input logic [SAMPLE_W-1:0] sample,
                                output bsw_rsp_type res);
      logic [CODE_W-1:0] code;
      logic [STEP_W-1:0] step_used;
      logic [15:0]       acc_sum;
      code = BTN_NONE;

      // Button first: press latch and ladder decode, then its action.
      if (sample_valid) begin
         if (sample > cfg_release) begin
            btn_latched = 1'b0;
            leds_l = LED_L_OFF;
            leds_b = LED_B_RELEASE;
         end else if (btn_latched) begin
            leds_b = LED_B_HELD;
            code = BTN_RIGHT;
         end else begin
            btn_latched = 1'b1;
            if (sample < cfg_right) begin
               leds_b = LED_B_HELD;
               code = BTN_RIGHT;
            end else if (sample < cfg_up) begin
               leds_l = LED_L_UP;
               code = BTN_UP;
            end else if (sample < cfg_down) begin
               leds_l = LED_L_DOWN;
               code = BTN_DOWN;
            end else if (sample < cfg_left) begin
               leds_l = LED_L_LEFT;
               code = BTN_LEFT;
            end else if (sample <= cfg_select) begin
               leds_l = LED_L_SELECT;
               code = BTN_SELECT;
            end
         end
         case (code)
            BTN_UP: begin
               lap_from  = lap_base;
               lap_to    = watch_time;
               lap_base  = watch_time;
               lap_shown = 1'b1;
            end
            BTN_DOWN: begin
               lap_base  = '0;
               lap_shown = 1'b0;
            end
            BTN_LEFT: begin
               watch_time    = '0;
               lap_base      = '0;
               watch_running = 1'b0;
            end
            BTN_SELECT: watch_running = ~watch_running;
            default: ;
         endcase
      end

      // Then the tick: fractional accumulator with the step clamped to the limit.
      if (tick) begin
         step_used = (cfg_step > cfg_limit) ? cfg_limit : cfg_step;
         acc_sum = 16'(tick_acc) + 16'(step_used);
         if (acc_sum >= 16'(cfg_limit)) begin
            if (watch_running) begin
               watch_time = next_tenth(watch_time);
               if (watch_time == '0) wrap_count++;
            end
            acc_sum = acc_sum - 16'(cfg_limit);
         end
         tick_acc = acc_sum[ACCUM_W-1:0];
      end

      res.time_digits     = watch_time;
      res.shown_lap_start = lap_shown ? lap_from : '0;
      res.shown_lap_end   = lap_shown ? lap_to : '0;
      res.lap_visible     = lap_shown;
      res.running         = watch_running;
      res.button_code     = code;
      res.led_bank_b      = leds_b;
      res.led_bank_l      = leds_l;
   endtask

   task automatic check_field(input string name, input logic [DIGITS_W-1:0] want,
                              input logic [DIGITS_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         fail_count++;
      end
   endtask

   // Sample both handshakes at the rising edge: check results, then predict.
   always @(posedge clock) begin : watch_monitor
      bsw_rsp_type want;
      bsw_rsp_type fresh;
      if (!reset) begin
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("bcd_stopwatch_with_lap_tb NOT OK");
            $finish;
         end else begin
            if (rsp_if.valid && rsp_if.ready) begin
               results_seen++;
               if (expected_results.size() == 0) begin
                  $error("result beat arrived with no expected beat waiting");
                  fail_count++;
               end else begin
                  want = expected_results.pop_front();
                  check_field("time_digits", want.time_digits, rsp_if.time_digits);
                  check_field("shown_lap_start", want.shown_lap_start,
                              rsp_if.shown_lap_start);
                  check_field("shown_lap_end", want.shown_lap_end, rsp_if.shown_lap_end);
                  check_field("lap_visible", 20'(want.lap_visible), 20'(rsp_if.lap_visible));
                  check_field("running", 20'(want.running), 20'(rsp_if.running));
                  check_field("button_code", 20'(want.button_code), 20'(rsp_if.button_code));
                  check_field("led_bank_b", 20'(want.led_bank_b), 20'(rsp_if.led_bank_b));
                  check_field("led_bank_l", 20'(want.led_bank_l), 20'(rsp_if.led_bank_l));
               end
            end
            if (req_if.valid && req_if.ready) begin
               predict_watch(req_if.tick, req_if.sample_valid, req_if.adc_sample, fresh);
               expected_results.push_back(fresh);
               accepted_beats++;
            end
         end
      end
   end

   // Driver: offer queued beats at the falling edge, with random gaps.
   always @(negedge clock) begin : beat_driver
      watch_beat_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && accepted_beats != offered_beats) begin
         // Current beat not yet taken; hold it.
      end else if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         nxt = pending_beats.pop_front();
         req_if.valid        <= 1'b1;
         req_if.tick         <= nxt.tick;
         req_if.sample_valid <= nxt.sample_valid;
         req_if.adc_sample   <= nxt.adc_sample;
         offered_beats++;
      end else begin
         req_if.valid        <= 1'b0;
         req_if.tick         <= 1'($urandom_range(1));
         req_if.sample_valid <= 1'($urandom_range(1));
         req_if.adc_sample   <= 10'($urandom_range(1023));
      end
   end

   // Receiver: random stalls, plus two long hold-offs that back up the input.
   int hold_left  = 0;
   int holds_done = 0;
   always @(negedge clock) begin : result_receiver
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (holds_done < 2 && accepted_beats >= (holds_done == 0 ? 120 : 1000)) begin
         rsp_if.ready <= 1'b0;
         hold_left  = HOLD_CYCLES;
         holds_done = holds_done + 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void push_beat(input logic tick, input logic sample_valid,
                                     input logic [SAMPLE_W-1:0] sample);
      watch_beat_type b;
      b.tick = tick;
      b.sample_valid = sample_valid;
      b.adc_sample = sample;
      pending_beats.push_back(b);
      pushed_beats++;
   endfunction

   // A pressed sample: anywhere up to the release level, or right around one threshold.
   function automatic logic [SAMPLE_W-1:0] press_sample();
      logic [LEVEL_W-1:0] lvl;
      if ($urandom_range(1)) return 10'($urandom_range(int'(cfg_release)));
      case ($urandom_range(4))
         0: lvl = cfg_right;
         1: lvl = cfg_up;
         2: lvl = cfg_down;
         3: lvl = cfg_left;
         default: lvl = cfg_select;
      endcase
      return lvl + 10'($urandom_range(2)) - 10'd1;
   endfunction

   function automatic logic [SAMPLE_W-1:0] release_sample();
      if (cfg_release == 10'd1023) return 10'd1023;
      return 10'($urandom_range(1023, int'(cfg_release) + 1));
   endfunction

   // Press, up to three held or empty beats, then release; ticks mixed in throughout.
   function automatic int push_gesture();
      int holds;
      holds = $urandom_range(3);
      push_beat($urandom_range(99) < 60, 1'b1, press_sample());
      for (int k = 0; k < holds; k++) begin
         if ($urandom_range(1)) push_beat($urandom_range(99) < 60, 1'b0,
                                          10'($urandom_range(1023)));
         else push_beat($urandom_range(99) < 60, 1'b1, press_sample());
      end
      push_beat($urandom_range(99) < 60, 1'b1, release_sample());
      return holds + 2;
   endfunction

   // Register writes happen only while the block is idle, so the shadow
   // copy can follow at once.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_TICK_STEP:     cfg_step    = val[STEP_W-1:0];
         REG_TICK_LIMIT:    cfg_limit   = val[STEP_W-1:0];
         REG_RELEASE_LEVEL: cfg_release = val;
         REG_RIGHT_LEVEL:   cfg_right   = val;
         REG_UP_LEVEL:      cfg_up      = val;
         REG_DOWN_LEVEL:    cfg_down    = val;
         REG_LEFT_LEVEL:    cfg_left    = val;
         default:           cfg_select  = val;
      endcase
   endtask

   task automatic apply_setting(input int step, input int limit, input int rel,
                                input int rgt, input int up, input int dn,
                                input int lft, input int sel);
      write_reg(REG_TICK_STEP, 10'(step));
      write_reg(REG_TICK_LIMIT, 10'(limit));
      write_reg(REG_RELEASE_LEVEL, 10'(rel));
      write_reg(REG_RIGHT_LEVEL, 10'(rgt));
      write_reg(REG_UP_LEVEL, 10'(up));
      write_reg(REG_DOWN_LEVEL, 10'(dn));
      write_reg(REG_LEFT_LEVEL, 10'(lft));
      write_reg(REG_SELECT_LEVEL, 10'(sel));
      @(negedge clock);
      csr_we <= 1'b0;
      settings_count++;
   endtask

   // Wait until every queued beat is in and every result is out.
   task automatic wait_idle();
      while (accepted_beats != pushed_beats || expected_results.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   initial begin : stimulus
      int n;
      int lv[6];
      int base;
      req_if.valid        = 1'b0;
      req_if.tick         = 1'b0;
      req_if.sample_valid = 1'b0;
      req_if.adc_sample   = '0;
      rsp_if.ready        = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      settings_count = 1;

      // Directed beats under the reset levels.
      push_beat(1'b1, 1'b0, 10'd0);      // tick while stopped, no sample
      push_beat(1'b0, 1'b1, 10'd1023);   // release, top of range
      push_beat(1'b1, 1'b1, 10'd0);      // right at the bottom of range
      push_beat(1'b0, 1'b1, 10'd0);      // held
      push_beat(1'b0, 1'b1, 10'd1023);
      push_beat(1'b1, 1'b1, 10'd790);    // select at its level: start
      push_beat(1'b1, 1'b1, 10'd791);    // at release level: still held
      push_beat(1'b0, 1'b1, 10'd792);    // just above release level
      for (int k = 0; k < 6; k++) push_beat(1'b1, 1'b0, 10'h2AA);
      push_beat(1'b1, 1'b1, 10'd194);    // up: first lap
      push_beat(1'b0, 1'b1, 10'd1023);
      push_beat(1'b1, 1'b1, 10'd50);     // up at the right level: second lap
      push_beat(1'b0, 1'b1, 10'd1023);
      push_beat(1'b1, 1'b1, 10'd379);    // down blanks the lap row
      push_beat(1'b0, 1'b1, 10'd1023);
      push_beat(1'b1, 1'b1, 10'd554);    // left clears and stops
      push_beat(1'b0, 1'b1, 10'd1023);
      push_beat(1'b0, 1'b1, 10'd791);    // no level matches, latch set
      push_beat(1'b1, 1'b1, 10'd1023);
      push_beat(1'b1, 1'b0, 10'h155);
      wait_idle();

      // Random phases, each under its own register setting.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph < 3) begin
            send_idle_pct = 23;
            recv_idle_pct = 56;
         end else if (ph < 6) begin
            send_idle_pct = 56;
            recv_idle_pct = 23;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         base = 0;
         for (int k = 0; k < 6; k++) begin
            base = base + $urandom_range(170);
            lv[k] = base;
         end
         case (ph)
            0: apply_setting(10, 61, 791, 50, 195, 380, 555, 790);
            1: apply_setting(255, 255, lv[5], lv[0], lv[1], lv[2], lv[3], lv[4]);
            2: apply_setting(1, 1, 0, 0, 0, 0, 0, 0);
            3: apply_setting(200, 7, 791, 50, 195, 380, 555, 790);   // step above limit
            4: apply_setting(1, 255, 1023, 0, 1023, 1023, 1023, 1023);
            5: apply_setting($urandom_range(1, 255), 0, lv[5], lv[0], lv[1], lv[2], lv[3],
                             lv[4]);                                   // zero limit
            6: apply_setting($urandom_range(1, 255), $urandom_range(1, 255),
                             $urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                             $urandom_range(1023), $urandom_range(1023), $urandom_range(1023));
            7: apply_setting(37, 61, lv[5], lv[0], lv[1], lv[2], lv[3], lv[4]);
            default: apply_setting($urandom_range(1, 255), $urandom_range(1, 255),
                                   lv[5], lv[0], lv[1], lv[2], lv[3], lv[4]);
         endcase
         n = 0;
         while (n < PHASE_BEATS) begin
            if ($urandom_range(99) < 70) begin
               n += push_gesture();
            end else begin
               push_beat(1'($urandom_range(1)), 1'($urandom_range(1)),
                         10'($urandom_range(1023)));
               n++;
            end
         end
         wait_idle();
      end

      // Short run: clear, start, then a tenth per tick.
      apply_setting(1, 1, 791, 50, 195, 380, 555, 790);
      push_beat(1'b0, 1'b1, 10'd1023);
      push_beat(1'b0, 1'b1, 10'd500);
      push_beat(1'b0, 1'b1, 10'd1023);
      push_beat(1'b0, 1'b1, 10'd700);
      push_beat(1'b0, 1'b1, 10'd1023);
      for (int k = 0; k < WRAP_TICKS; k++) push_beat(1'b1, 1'b0, 10'($urandom_range(1023)));
      wait_idle();
      repeat (5) @(negedge clock);

      if (expected_results.size() != 0) begin
         $error("%0d expected result beats never arrived", expected_results.size());
         fail_count++;
      end
      $display("Checked %0d result beats for %0d input beats over %0d register settings.",
               results_seen, accepted_beats, settings_count);
      $display("The watch wrapped past 99:59.9 %0d time(s); %0d mismatches.",
               wrap_count, fail_count);
      if (fail_count == 0) begin
         $display("bcd_stopwatch_with_lap_tb OK");
      end else begin
         $display("bcd_stopwatch_with_lap_tb NOT OK");
      end
      $finish;
   end

endmodule
